// ===== hdl/ps2hb_pkg.sv =====
// Shared types and constants for the PS/2 host bit engine with receive FIFO.
package ps2hb_pkg;

   localparam int FIFO_DEPTH = 64;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   localparam logic [1:0] REQ_EDGE = 2'd0;
   localparam logic [1:0] REQ_SEND = 2'd1;
   localparam logic [1:0] REQ_POP  = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic       data_line;
      logic       gap_expired;
      logic [7:0] send_byte;
   } req_item_type;

   typedef struct packed {
      logic       pull_data_low;
      logic       request_to_send;
      logic       byte_stored;
      logic       frame_rejected;
      logic       fifo_overflow;
      logic [7:0] read_byte;
      logic       fifo_has_data;
      logic       sending;
   } rsp_item_type;

   // What the bit engine reports for the transaction being taken
   typedef struct packed {
      logic       frame_good;
      logic       frame_bad;
      logic [7:0] rx_byte;
      logic       line_drive;
      logic       sending;
      logic       rts;
   } engine_event_type;

endpackage

// ===== hdl/ps2hb_bit_engine.sv =====
// PS/2 bit-level receive/transmit framing, one clock edge per transaction while step_en is high.
module ps2hb_bit_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  ps2hb_pkg::req_item_type     item,
   output ps2hb_pkg::engine_event_type ev
);
   import ps2hb_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_REQ   = 3'b010,
      PH_SHIFT = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_index_ff, bit_index_in;
   logic       parity_ff, parity_in;
   logic [7:0] rx_shift_ff, rx_shift_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic       drive_ff, drive_in;
   logic       good, bad, rts;

   always_comb begin
      logic [3:0] bi;
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      parity_in    = parity_ff;
      rx_shift_in  = rx_shift_ff;
      tx_byte_in   = tx_byte_ff;
      drive_in     = drive_ff;
      good         = 1'b0;
      bad          = 1'b0;
      rts          = 1'b0;
      bi           = bit_index_ff;
      case (item.req_type)
         REQ_EDGE: begin
            case (phase_ff)
               PH_REQ: begin
                  // first edge after the request is skipped
                  phase_in     = PH_SHIFT;
                  bit_index_in = 4'd0;
                  parity_in    = 1'b0;
               end
               PH_SHIFT: begin
                  if (bit_index_ff <= 4'd7) begin
                     if (tx_byte_ff[bit_index_ff[2:0]]) begin
                        parity_in = ~parity_ff;
                        drive_in  = 1'b0;
                     end else begin
                        drive_in = 1'b1;
                     end
                     bit_index_in = bit_index_ff + 4'd1;
                  end else if (bit_index_ff == 4'd8) begin
                     drive_in     = parity_ff;
                     bit_index_in = bit_index_ff + 4'd1;
                  end else if (bit_index_ff == 4'd9) begin
                     drive_in     = 1'b0;
                     bit_index_in = bit_index_ff + 4'd1;
                  end else begin
                     // ack edge
                     drive_in     = 1'b0;
                     phase_in     = PH_IDLE;
                     parity_in    = 1'b0;
                     bit_index_in = 4'd0;
                  end
               end
               default: begin
                  if (item.gap_expired) begin
                     bi = 4'd0;
                  end
                  bit_index_in = bi;
                  if (bi == 4'd0) begin
                     if (!item.data_line) begin
                        rx_shift_in  = 8'd0;
                        parity_in    = 1'b0;
                        bit_index_in = 4'd1;
                     end
                  end else if (bi <= 4'd8) begin
                     rx_shift_in  = {item.data_line, rx_shift_ff[7:1]};
                     parity_in    = parity_ff ^ item.data_line;
                     bit_index_in = bi + 4'd1;
                  end else if (bi == 4'd9) begin
                     parity_in    = parity_ff ^ item.data_line;
                     bit_index_in = bi + 4'd1;
                  end else begin
                     good         = item.data_line & parity_ff;
                     bad          = ~(item.data_line & parity_ff);
                     bit_index_in = 4'd0;
                  end
               end
            endcase
         end
         REQ_SEND: begin
            phase_in     = PH_REQ;
            bit_index_in = 4'd0;
            tx_byte_in   = item.send_byte;
            drive_in     = 1'b1;
            rts          = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_index_ff <= 4'd0;
         parity_ff    <= 1'b0;
         rx_shift_ff  <= 8'd0;
         tx_byte_ff   <= 8'd0;
         drive_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         parity_ff    <= parity_in;
         rx_shift_ff  <= rx_shift_in;
         tx_byte_ff   <= tx_byte_in;
         drive_ff     <= drive_in;
      end
   end

   assign ev.frame_good = good;
   assign ev.frame_bad  = bad;
   assign ev.rx_byte    = rx_shift_ff;
   assign ev.line_drive = drive_in;
   assign ev.sending    = (phase_in != PH_IDLE);
   assign ev.rts        = rts;

endmodule

// ===== hdl/ps2_host_bit_engine_with_fifo_unit.sv =====
// Top level: PS/2 host bit engine, receive FIFO memory and result pipeline.
//
//   channel | ports                         | direction | payload
//   --------+-------------------------------+-----------+------------------------
//   request | req_valid, req_stall, req_item| in        | req_item_type
//   result  | rsp_valid, rsp_stall, rsp_item| out       | rsp_item_type
//
// One transaction per cycle while req_stall is low; each gives one result via
// the middle stage (engine and FIFO memory read) and then the output register.
// The read port of the FIFO memory sets the depth: read data is registered.
// Synchronous active-high reset clears framing state and pointers; the memory
// is not cleared, a pop only reads slots that were pushed.
// With rsp_stall high, one more transaction is taken into the middle stage.
module ps2_host_bit_engine_with_fifo_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ps2hb_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ps2hb_pkg::rsp_item_type rsp_item
);
   import ps2hb_pkg::*;

   localparam logic [FIFO_PTR_W-1:0] FIFO_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);

   engine_event_type ev;

   logic                  accept, out_free;
   logic                  push, pop, full, empty;
   logic [FIFO_PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [FIFO_PTR_W-1:0] head_next, tail_next;
   logic [7:0]            fifo_mem [FIFO_DEPTH];
   logic [7:0]            rdata_ff;

   logic         s1_valid_ff, s1_valid_in;
   rsp_item_type s1_item_ff, s1_item_in;
   logic         s1_pop_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = s1_valid_ff & ~out_free;
   assign accept    = req_valid & ~req_stall;

   ps2hb_bit_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .item    (req_item),
      .ev      (ev)
   );

   // ring pointers, one slot kept empty
   assign head_next = (head_ff == FIFO_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == FIFO_LAST) ? '0 : tail_ff + 1'b1;
   assign full      = (head_next == tail_ff);
   assign empty     = (head_ff == tail_ff);
   assign push      = accept & ev.frame_good & ~full;
   assign pop       = accept & (req_item.req_type == REQ_POP) & ~empty;
   assign head_in   = push ? head_next : head_ff;
   assign tail_in   = pop ? tail_next : tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // push and pop never address the same slot in one cycle
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[head_ff] <= ev.rx_byte;
      end
      if (pop) begin
         rdata_ff <= fifo_mem[tail_ff];
      end
   end

   always_comb begin
      s1_item_in                 = '0;
      s1_item_in.pull_data_low   = ev.line_drive;
      s1_item_in.request_to_send = ev.rts;
      s1_item_in.byte_stored     = push;
      s1_item_in.frame_rejected  = ev.frame_bad;
      s1_item_in.fifo_overflow   = ev.frame_good & full;
      s1_item_in.fifo_has_data   = (head_in != tail_in);
      s1_item_in.sending         = ev.sending;
   end

   assign s1_valid_in = accept | (s1_valid_ff & ~out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
         s1_pop_ff  <= pop;
      end
   end

   always_comb begin
      rsp_item_in           = s1_item_ff;
      rsp_item_in.read_byte = s1_pop_ff ? rdata_ff : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== hdl/ps2hb_checker.sv =====
// Port-level checks for the PS/2 host bit engine top level, with its bind.
module ps2hb_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input ps2hb_pkg::req_item_type req_item,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input ps2hb_pkg::rsp_item_type rsp_item
);
   import ps2hb_pkg::*;

   // a stalled request stays offered and unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_item))
      else $error("request changed while stalled");

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // a frame ends in at most one way
   a_frame_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_item.byte_stored, rsp_item.frame_rejected,
                              rsp_item.fifo_overflow}))
      else $error("more than one frame outcome");

   // a stored byte leaves the FIFO non-empty
   a_store_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.byte_stored |-> rsp_item.fifo_has_data)
      else $error("byte stored but FIFO empty");

   // a send request drives the start bit and marks sending
   a_rts_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.request_to_send |->
         rsp_item.pull_data_low && rsp_item.sending)
      else $error("send request without start bit");

endmodule

bind ps2_host_bit_engine_with_fifo_unit ps2hb_checker u_ps2hb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
